// ----- design/q16_16_fixed_point_alu_assert.svh -----
// assertion macros for the q16.16 alu
`ifndef Q16_16_FIXED_POINT_ALU_ASSERT_SVH
`define Q16_16_FIXED_POINT_ALU_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, disabled during reset
`define Q16_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("q16 alu assertion failed");
// next-cycle implication on clk, disabled during reset
`define Q16_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("q16 alu assertion failed");
`else
`define Q16_ASSERT_NOW(lbl, ante, cons)
`define Q16_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/q16alu_pkg.sv -----
package q16alu_pkg;

    // operation codes
    typedef enum logic [2:0] {
        FN_INT_TO_FIX = 3'd0,
        FN_FIX_TO_INT = 3'd1,
        FN_ADD        = 3'd2,
        FN_SUB        = 3'd3,
        FN_MUL        = 3'd4,
        FN_DIV        = 3'd5
    } func_t;

    localparam int WORD_W = 32;

    // control that rides along the divider chain with each item
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              neg;
        logic              dz;
        logic [WORD_W-1:0] res;
    } cell_ctrl_t;

endpackage

// ----- design/q16alu_front.sv -----
module q16alu_front
    import q16alu_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int DQ_W      = WORD_W + FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     op_valid,
    input  logic [2:0]               func,
    input  logic signed [WORD_W-1:0] operand_a,
    input  logic signed [WORD_W-1:0] operand_b,
    output cell_ctrl_t               ctrl_out,
    output logic [DQ_W-1:0]          dq_out,
    output logic [WORD_W-1:0]        dvs_out
);

    localparam logic signed [2*WORD_W-1:0] MUL_BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    // stage a: capture operands and form the full product
    logic                       vld_a_reg;
    logic [2:0]                 fn_a_reg;
    logic signed [WORD_W-1:0]   a_reg;
    logic signed [WORD_W-1:0]   b_reg;
    logic signed [2*WORD_W-1:0] prod_reg;

    // stage b: simple results and divider setup
    cell_ctrl_t                 ctrl_reg;
    cell_ctrl_t                 ctrl_next;
    logic [DQ_W-1:0]            dq_reg;
    logic [DQ_W-1:0]            dq_next;
    logic [WORD_W-1:0]          dvs_reg;
    logic [WORD_W-1:0]          dvs_next;

    logic signed [2*WORD_W-1:0] prod_biased;
    logic [WORD_W-1:0]          abs_a;
    logic [WORD_W-1:0]          abs_b;

    // stage a control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= op_valid;
        end
    end

    // stage a payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fn_a_reg <= func;
            a_reg    <= operand_a;
            b_reg    <= operand_b;
            prod_reg <= operand_a * operand_b;
        end
    end

    // multiply rounds toward zero: bias negative products before the shift
    assign prod_biased = prod_reg + (prod_reg[2*WORD_W-1] ? MUL_BIAS : '0);

    // magnitudes for the unsigned divider
    assign abs_a = a_reg[WORD_W-1] ? WORD_W'(-a_reg) : WORD_W'(a_reg);
    assign abs_b = b_reg[WORD_W-1] ? WORD_W'(-b_reg) : WORD_W'(b_reg);

    // stage b result select
    always_comb
    begin
        ctrl_next        = '0;
        ctrl_next.valid  = vld_a_reg;
        dq_next          = {abs_a, {FRAC_BITS{1'b0}}};
        dvs_next         = abs_b;
        unique case (fn_a_reg)
            FN_INT_TO_FIX:
            begin
                ctrl_next.res = {a_reg[WORD_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            end
            FN_FIX_TO_INT:
            begin
                ctrl_next.res = WORD_W'(a_reg >>> FRAC_BITS);
            end
            FN_ADD:
            begin
                ctrl_next.res = WORD_W'(a_reg + b_reg);
            end
            FN_SUB:
            begin
                ctrl_next.res = WORD_W'(a_reg - b_reg);
            end
            FN_MUL:
            begin
                ctrl_next.res = prod_biased[FRAC_BITS+WORD_W-1:FRAC_BITS];
            end
            FN_DIV:
            begin
                ctrl_next.is_div = 1'b1;
                ctrl_next.neg    = a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
                ctrl_next.dz     = (b_reg == '0);
            end
            default:
            begin
                ctrl_next.res = '0;
            end
        endcase
    end

    // stage b control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // stage b payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq_reg  <= dq_next;
            dvs_reg <= dvs_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign dq_out   = dq_reg;
    assign dvs_out  = dvs_reg;

endmodule

// ----- design/q16alu_div_cell.sv -----
module q16alu_div_cell
    import q16alu_pkg::*;
#(
    parameter int DQ_W = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cell_ctrl_t        ctrl_in,
    input  logic [WORD_W-1:0] rem_in,
    input  logic [DQ_W-1:0]   dq_in,
    input  logic [WORD_W-1:0] dvs_in,
    output cell_ctrl_t        ctrl_out,
    output logic [WORD_W-1:0] rem_out,
    output logic [DQ_W-1:0]   dq_out,
    output logic [WORD_W-1:0] dvs_out
);

    cell_ctrl_t        ctrl_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic [DQ_W-1:0]   dq_reg;
    logic [DQ_W-1:0]   dq_next;
    logic [WORD_W-1:0] dvs_reg;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W+1:0] diff;
    logic              qbit;

    // one restoring step: bring in the next dividend bit, try to subtract
    assign rem_sh = {rem_in, dq_in[DQ_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_in};
    assign qbit   = ~diff[WORD_W+1];

    always_comb
    begin
        rem_next = qbit ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
        dq_next  = {dq_in[DQ_W-2:0], qbit};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            dvs_reg <= dvs_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign dq_out   = dq_reg;
    assign dvs_out  = dvs_reg;

endmodule

// ----- design/q16_16_fixed_point_alu.sv -----
// path: an item passes front stage a, front stage b, the divider cells and the output register
// throughput: one item per cycle while op_stall is low, set by one divider cell per quotient bit
// (32 + FRAC_BITS cells) behind a two-stage front end with a registered multiplier
// the chain moves while its last cell is empty, even with a result held at the output
// reset: rst_n asynchronous active low clears all valid bits, no item in flight
`include "q16_16_fixed_point_alu_assert.svh"

module q16_16_fixed_point_alu
    import q16alu_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     op_valid,
    output logic                     op_stall,
    input  logic [2:0]               func,
    input  logic signed [WORD_W-1:0] operand_a,
    input  logic signed [WORD_W-1:0] operand_b,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic signed [WORD_W-1:0] result,
    output logic                     divide_by_zero
);

    localparam int DQ_W = WORD_W + FRAC_BITS;

    cell_ctrl_t        ctrl_chain [0:DQ_W];
    logic [WORD_W-1:0] rem_chain  [0:DQ_W];
    logic [DQ_W-1:0]   dq_chain   [0:DQ_W];
    logic [WORD_W-1:0] dvs_chain  [0:DQ_W];

    logic              en;
    logic              out_load;
    cell_ctrl_t        last;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] fin_res;

    logic              res_valid_reg;
    logic [WORD_W-1:0] result_reg;
    logic              dz_reg;

    // chain advances unless the last cell holds an item that cannot leave
    assign last     = ctrl_chain[DQ_W];
    assign en       = ~(res_valid_reg & res_stall & last.valid);
    assign out_load = ~res_valid_reg | ~res_stall;
    assign op_stall = ~en;

    // operand capture, multiply and simple operations
    q16alu_front #(
        .FRAC_BITS (FRAC_BITS),
        .DQ_W      (DQ_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .op_valid  (op_valid),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctrl_out  (ctrl_chain[0]),
        .dq_out    (dq_chain[0]),
        .dvs_out   (dvs_chain[0])
    );

    assign rem_chain[0] = '0;

    // divider cells, one quotient bit each
    for (genvar i = 0; i < DQ_W; i++)
    begin : g_cell
        q16alu_div_cell #(
            .DQ_W (DQ_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (ctrl_chain[i]),
            .rem_in   (rem_chain[i]),
            .dq_in    (dq_chain[i]),
            .dvs_in   (dvs_chain[i]),
            .ctrl_out (ctrl_chain[i+1]),
            .rem_out  (rem_chain[i+1]),
            .dq_out   (dq_chain[i+1]),
            .dvs_out  (dvs_chain[i+1])
        );
    end

    // final sign fix for divide, zero on a zero divisor
    assign quot = dq_chain[DQ_W][WORD_W-1:0];

    always_comb
    begin
        priority if (!last.is_div)
        begin
            fin_res = last.res;
        end
        else if (last.dz)
        begin
            fin_res = '0;
        end
        else if (last.neg)
        begin
            fin_res = -quot;
        end
        else
        begin
            fin_res = quot;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= last.valid;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= fin_res;
            dz_reg     <= last.dz;
        end
    end

    assign res_valid      = res_valid_reg;
    assign result         = result_reg;
    assign divide_by_zero = dz_reg;

    // checks
    `Q16_ASSERT_NOW(a_dz_zero, res_valid && divide_by_zero, result == '0)
    `Q16_ASSERT_NOW(a_no_false_stall, !res_valid || !res_stall, !op_stall)
    `Q16_ASSERT_NOW(a_full_stall, res_valid && res_stall && last.valid, op_stall)
    `Q16_ASSERT_NEXT(a_hold_last, res_valid && res_stall && last.valid,
        last.valid && res_valid)

endmodule
